// File: rtl/rme_pkg.sv
// Shared constants, microcode format and control ROM for the RSA modular
// exponentiation block. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package rme_pkg;

  localparam int MOD_WIDTH = 16;
  localparam int EXP_WIDTH = 16;
  localparam int CNT_WIDTH = $clog2(MOD_WIDTH);
  localparam int STEP_WIDTH = 4;
  localparam int REG_IDX_WIDTH = 2;
  localparam int CFG_WIDTH = (MOD_WIDTH > EXP_WIDTH) ? MOD_WIDTH : EXP_WIDTH;

  // register indexes
  localparam logic [REG_IDX_WIDTH-1:0] REG_PUBLIC_EXP  = 2'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_PRIVATE_EXP = 2'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_MODULUS     = 2'd2;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  localparam logic [MOD_WIDTH-1:0] MODULUS_MIN = MOD_WIDTH'(2);

  // micro-ops
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_RED   = 3'd1; // one bit of base reduction
  localparam logic [2:0] OP_MULA  = 3'd2; // set up acc * base
  localparam logic [2:0] OP_MULB  = 3'd3; // set up base * base
  localparam logic [2:0] OP_MSTEP = 3'd4; // one shift-add step, write back at end
  localparam logic [2:0] OP_SHIFT = 3'd5; // exponent >> 1
  localparam logic [2:0] OP_EMIT  = 3'd6; // load output register

  // jump conditions
  localparam logic [2:0] COND_NEVER    = 3'd0;
  localparam logic [2:0] COND_ALWAYS   = 3'd1;
  localparam logic [2:0] COND_CNT_NZ   = 3'd2;
  localparam logic [2:0] COND_E_ZERO   = 3'd3;
  localparam logic [2:0] COND_E_EVEN   = 3'd4;
  localparam logic [2:0] COND_MB_NZ    = 3'd5;
  localparam logic [2:0] COND_OUT_BUSY = 3'd6;

  localparam logic DST_ACC  = 1'b0;
  localparam logic DST_BASE = 1'b1;

  // program steps
  localparam logic [STEP_WIDTH-1:0] ST_REDUCE = 4'd0;
  localparam logic [STEP_WIDTH-1:0] ST_ETEST  = 4'd1;
  localparam logic [STEP_WIDTH-1:0] ST_PARITY = 4'd2;
  localparam logic [STEP_WIDTH-1:0] ST_MULA   = 4'd3;
  localparam logic [STEP_WIDTH-1:0] ST_MLOOPA = 4'd4;
  localparam logic [STEP_WIDTH-1:0] ST_MULB   = 4'd5;
  localparam logic [STEP_WIDTH-1:0] ST_MLOOPB = 4'd6;
  localparam logic [STEP_WIDTH-1:0] ST_SHIFT  = 4'd7;
  localparam logic [STEP_WIDTH-1:0] ST_EMIT   = 4'd8;

  typedef struct packed {
    logic [2:0]            op;
    logic [2:0]            cond;
    logic [STEP_WIDTH-1:0] target;
    logic                  dst;
  } ucode_word_t;

  typedef struct packed {
    logic [2:0] op;
    logic       dst;
  } dp_ctrl_t;

  typedef struct packed {
    logic cnt_nz;
    logic e_zero;
    logic e_even;
    logic mb_nz;
    logic out_busy;
  } dp_status_t;

  // control program: taken jump goes to target, otherwise to step + 1
  function automatic ucode_word_t ucode_rom(input logic [STEP_WIDTH-1:0] step);
    ucode_word_t w;
    case (step)
      ST_REDUCE: w = '{OP_RED,   COND_CNT_NZ,   ST_REDUCE, DST_ACC};
      ST_ETEST:  w = '{OP_NONE,  COND_E_ZERO,   ST_EMIT,   DST_ACC};
      ST_PARITY: w = '{OP_NONE,  COND_E_EVEN,   ST_MULB,   DST_ACC};
      ST_MULA:   w = '{OP_MULA,  COND_NEVER,    ST_MULA,   DST_ACC};
      ST_MLOOPA: w = '{OP_MSTEP, COND_MB_NZ,    ST_MLOOPA, DST_ACC};
      ST_MULB:   w = '{OP_MULB,  COND_NEVER,    ST_MULB,   DST_BASE};
      ST_MLOOPB: w = '{OP_MSTEP, COND_MB_NZ,    ST_MLOOPB, DST_BASE};
      ST_SHIFT:  w = '{OP_SHIFT, COND_ALWAYS,   ST_ETEST,  DST_ACC};
      ST_EMIT:   w = '{OP_EMIT,  COND_OUT_BUSY, ST_EMIT,   DST_ACC};
      default:   w = '{OP_NONE,  COND_NEVER,    ST_REDUCE, DST_ACC};
    endcase
    return w;
  endfunction

  // (a + b) mod m for a, b < m
  function automatic logic [MOD_WIDTH-1:0] add_mod(input logic [MOD_WIDTH-1:0] a,
                                                   input logic [MOD_WIDTH-1:0] b,
                                                   input logic [MOD_WIDTH-1:0] m);
    logic [MOD_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MOD_WIDTH-1:0];
  endfunction

endpackage

// File: rtl/rme_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on rme_pkg.
`timescale 1ns / 1ps

module rme_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rme_pkg::dp_status_t status,
  output rme_pkg::dp_ctrl_t   ctrl,
  output logic              busy
);
  import rme_pkg::*;

  logic [STEP_WIDTH-1:0] step;
  logic [STEP_WIDTH-1:0] step_next;
  logic                  busy_next;
  ucode_word_t           word;
  logic                  take;

  assign word = ucode_rom(step);

  always_comb begin
    case (word.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_CNT_NZ:   take = status.cnt_nz;
      COND_E_ZERO:   take = status.e_zero;
      COND_E_EVEN:   take = status.e_even;
      COND_MB_NZ:    take = status.mb_nz;
      COND_OUT_BUSY: take = status.out_busy;
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    step_next = step;
    busy_next = busy;
    ctrl.op   = OP_NONE;
    ctrl.dst  = word.dst;
    if (!busy) begin
      if (start) begin
        step_next = ST_REDUCE;
        busy_next = 1'b1;
      end
    end else begin
      ctrl.op   = word.op;
      step_next = take ? word.target : step + 1'b1;
      // emit with a free output register ends the item
      if (word.op == OP_EMIT && !status.out_busy) begin
        busy_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_REDUCE;
      busy <= 1'b0;
    end else begin
      step <= step_next;
      busy <= busy_next;
    end
  end

endmodule

// File: rtl/rme_datapath.sv
// Datapath: config registers, base reduction, shift-add modular multiplier,
// exponent shifter and output register. Depends on rme_pkg.
`timescale 1ns / 1ps

module rme_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rme_pkg::REG_IDX_WIDTH-1:0] cfg_index,
  input  logic [rme_pkg::CFG_WIDTH-1:0]     cfg_data,
  input  logic                              start,
  input  logic                              mode,
  input  logic [rme_pkg::MOD_WIDTH-1:0]     value,
  input  logic                              last_in,
  input  rme_pkg::dp_ctrl_t                 ctrl,
  output rme_pkg::dp_status_t               status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rme_pkg::MOD_WIDTH-1:0]     result,
  output logic                              last_out
);
  import rme_pkg::*;

  logic [EXP_WIDTH-1:0] public_exp;
  logic [EXP_WIDTH-1:0] private_exp;
  logic [MOD_WIDTH-1:0] modulus;

  logic                 decrypt;
  logic                 last;
  logic [MOD_WIDTH-1:0] vreg;
  logic [CNT_WIDTH-1:0] cnt;
  logic [EXP_WIDTH-1:0] e;
  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] base;
  logic [MOD_WIDTH-1:0] ma;
  logic [MOD_WIDTH-1:0] mb;
  logic [MOD_WIDTH-1:0] macc;
  logic                 dst;

  logic [MOD_WIDTH:0]   red_shift;
  logic [MOD_WIDTH-1:0] red_next;
  logic [MOD_WIDTH-1:0] macc_sum;
  logic [MOD_WIDTH-1:0] ma_dbl;
  logic                 out_busy;

  // (2*base + bit) mod m, base < m
  always_comb begin
    red_shift = {base, vreg[cnt]};
    if (red_shift >= {1'b0, modulus}) begin
      red_shift = red_shift - {1'b0, modulus};
    end
    red_next = red_shift[MOD_WIDTH-1:0];
  end

  assign macc_sum = add_mod(macc, ma, modulus);
  assign ma_dbl   = add_mod(ma, ma, modulus);
  assign out_busy = out_valid && out_stall;

  assign status.cnt_nz   = (cnt != '0);
  assign status.e_zero   = (e == '0);
  assign status.e_even   = !e[0];
  assign status.mb_nz    = (mb != '0);
  assign status.out_busy = out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      public_exp  <= '0;
      private_exp <= '0;
      modulus     <= MODULUS_MIN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PUBLIC_EXP:  public_exp  <= cfg_data[EXP_WIDTH-1:0];
        REG_PRIVATE_EXP: private_exp <= cfg_data[EXP_WIDTH-1:0];
        REG_MODULUS:     modulus     <= (cfg_data[MOD_WIDTH-1:0] < MODULUS_MIN) ?
                                        MODULUS_MIN : cfg_data[MOD_WIDTH-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      decrypt <= mode;
      last    <= last_in;
      vreg    <= value;
      cnt     <= CNT_WIDTH'(MOD_WIDTH - 1);
      e       <= (mode == MODE_DECRYPT) ? private_exp : public_exp;
      acc     <= MOD_WIDTH'(1);
      base    <= '0;
    end else begin
      case (ctrl.op)
        OP_RED: begin
          base <= red_next;
          cnt  <= cnt - 1'b1;
        end
        OP_MULA: begin
          ma   <= acc;
          mb   <= base;
          macc <= '0;
          dst  <= ctrl.dst;
        end
        OP_MULB: begin
          ma   <= base;
          mb   <= base;
          macc <= '0;
          dst  <= ctrl.dst;
        end
        OP_MSTEP: begin
          if (mb != '0) begin
            if (mb[0]) begin
              macc <= macc_sum;
            end
            ma <= ma_dbl;
            mb <= mb >> 1;
          end else if (dst == DST_BASE) begin
            base <= macc;
          end else begin
            acc <= macc;
          end
        end
        OP_SHIFT: e <= e >> 1;
        default:  ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && !out_busy) begin
      result   <= (decrypt == MODE_DECRYPT) ? {{(MOD_WIDTH-8){1'b0}}, acc[7:0]} : acc;
      last_out <= last;
    end
  end

endmodule

// File: rtl/rsa_modular_exponentiation_top.sv
// Sequence: base reduction of the input, then per exponent bit a multiply loop
//   (one shift-add a cycle) for acc * base if the bit is odd and for base * base,
//   then an exponent shift; when the exponent is zero the result is emitted.
// Throughput: one item at a time; in_stall is high until the result is in the
//   output register, so a new beat is taken while the last result waits.
// Reset (rst, synchronous): sequencer idle, output empty, exponents 0, modulus 2.
`timescale 1ns / 1ps

module rsa_modular_exponentiation_top (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [rme_pkg::REG_IDX_WIDTH-1:0] cfg_index,
  input  logic [rme_pkg::CFG_WIDTH-1:0]     cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic [rme_pkg::MOD_WIDTH-1:0]     value,
  input  logic                              last_in,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rme_pkg::MOD_WIDTH-1:0]     result,
  output logic                              last_out
);
  import rme_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;
  logic       busy;
  logic       start;

  // one item in flight; the output register frees the sequencer on emit
  assign in_stall = busy;
  assign start    = in_valid && !busy;

  // step counter + control ROM
  rme_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // registers, reduction and shift-add modular multiplier
  rme_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .mode      (mode),
    .value     (value),
    .last_in   (last_in),
    .ctrl      (ctrl),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .last_out  (last_out)
  );

endmodule
